// ===== rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants and types for the bilinear RGB scaler.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int DEF_MAX_SRC_WIDTH  = 512;
    localparam int DEF_MAX_SRC_HEIGHT = 512;
    localparam int DEF_FRAC_BITS      = 8;

    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int POS_W   = 12;
    localparam int SRC_W   = 10;
    localparam int DST_W   = 13;
    localparam int STEP_W  = 18;
    localparam int PROD_W  = POS_W + STEP_W;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_STEP_X     = 3'd4,
        CFG_STEP_Y     = 3'd5
    } t_cfg_idx;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

endpackage

// ===== rtl/brs_ram.sv =====
// ----------------------------------------------------------------------------
// brs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bilinear_rgb_image_scaler_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_rgb_image_scaler_core
// Bilinear RGB scaler: loads a source frame, answers destination pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: tuser = kind (0 load, 1 request). Loads write one source
//    pixel; requests ask for one destination pixel. Loads give no output item.
//  - Master stream: one item per request: colour and in_range flag.
//  - Config channel: index/data writes, always ready; write only when idle.
//  - A request item passes capture, multiply, clamp, store read + weights and
//    blend into the output register before it appears on the master side.
//  - Throughput: one item per cycle unless the receiver stalls. The frame store
//    is split in four banks by row and column parity, so a request's four taps
//    come out of four RAM read ports at once; loads write through the same
//    pipeline slot, keeping store order equal to item order without forwarding.
//  - Reset clears the pipeline and sets the registers to their defaults; the
//    frame store is not cleared, an entry must be loaded before it is read.
//  - When the receiver stalls the whole pipeline holds; o_s_tready falls while
//    a result waits and the receiver is not ready.
// ----------------------------------------------------------------------------
module bilinear_rgb_image_scaler_core #(
    parameter int MAX_SRC_WIDTH  = brs_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = brs_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int FRAC_BITS      = brs_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // pos_x[11:0], pos_y[23:12], in_red[31:24], in_green[39:32], in_blue[47:40]
    input  logic [brs_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // kind[0]
    input  logic                                i_s_tuser,
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], in_range[24], zero[31:25]
    output logic [brs_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // config
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [brs_pkg::STEP_W-1:0]          i_cfg_data
);

    localparam int XW     = (MAX_SRC_WIDTH  > 1) ? $clog2(MAX_SRC_WIDTH)  : 1;
    localparam int YW     = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BDEPTH = HALF_W * HALF_H;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int WW     = FRAC_BITS + 1;            // weight width, max = one
    localparam int ACC_W  = WW + brs_pkg::CHAN_W + 2;
    localparam int IPW    = brs_pkg::PROD_W - FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [brs_pkg::SRC_W-1:0]  r_src_width, r_src_height;
    logic [brs_pkg::DST_W-1:0]  r_dst_width, r_dst_height;
    logic [brs_pkg::STEP_W-1:0] r_step_x, r_step_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= brs_pkg::SRC_W'(512);
            r_src_height <= brs_pkg::SRC_W'(512);
            r_dst_width  <= brs_pkg::DST_W'(512);
            r_dst_height <= brs_pkg::DST_W'(512);
            r_step_x     <= brs_pkg::STEP_W'(256);
            r_step_y     <= brs_pkg::STEP_W'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                brs_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[brs_pkg::SRC_W-1:0];
                brs_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[brs_pkg::SRC_W-1:0];
                brs_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[brs_pkg::DST_W-1:0];
                brs_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[brs_pkg::DST_W-1:0];
                brs_pkg::CFG_STEP_X:     r_step_x     <= i_cfg_data;
                brs_pkg::CFG_STEP_Y:     r_step_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last source column / row after clamping size to 1..MAX
    logic [XW-1:0] w_last_x;
    logic [YW-1:0] w_last_y;
    logic [brs_pkg::DST_W-1:0] w_dw, w_dh;

    always_comb begin
        if (r_src_width == '0)
            w_last_x = '0;
        else if (13'(r_src_width) > 13'(MAX_SRC_WIDTH))
            w_last_x = XW'(MAX_SRC_WIDTH - 1);
        else
            w_last_x = XW'(r_src_width - brs_pkg::SRC_W'(1));
        if (r_src_height == '0)
            w_last_y = '0;
        else if (13'(r_src_height) > 13'(MAX_SRC_HEIGHT))
            w_last_y = YW'(MAX_SRC_HEIGHT - 1);
        else
            w_last_y = YW'(r_src_height - brs_pkg::SRC_W'(1));
        w_dw = (r_dst_width  == '0) ? brs_pkg::DST_W'(1) : r_dst_width;
        w_dh = (r_dst_height == '0) ? brs_pkg::DST_W'(1) : r_dst_height;
    end

    // ---------------- pipeline control ----------------
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_ov;

    assign w_en       = !r_ov || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_ov;

    // stage 1: capture item, range checks
    logic                        r1_kind, r1_ok;
    logic [brs_pkg::POS_W-1:0]   r1_px, r1_py;
    logic [brs_pkg::PIX_W-1:0]   r1_pix;

    logic [brs_pkg::POS_W-1:0] w_px, w_py;
    assign w_px = i_s_tdata[11:0];
    assign w_py = i_s_tdata[23:12];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind <= i_s_tuser;
            r1_px   <= w_px;
            r1_py   <= w_py;
            // stored as red, green, blue from the top bits down
            r1_pix  <= {i_s_tdata[31:24], i_s_tdata[39:32], i_s_tdata[47:40]};
            if (i_s_tuser == brs_pkg::KIND_LOAD)
                r1_ok <= (13'(w_px) < 13'(MAX_SRC_WIDTH)) && (13'(w_py) < 13'(MAX_SRC_HEIGHT));
            else
                r1_ok <= ({1'b0, w_px} < w_dw) && ({1'b0, w_py} < w_dh);
        end
    end

    // stage 2: position times step
    logic                        r2_kind, r2_ok;
    logic [brs_pkg::POS_W-1:0]   r2_px, r2_py;
    logic [brs_pkg::PIX_W-1:0]   r2_pix;
    logic [brs_pkg::PROD_W-1:0]  r2_sx, r2_sy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_kind <= r1_kind;
            r2_ok   <= r1_ok;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_pix  <= r1_pix;
            r2_sx   <= brs_pkg::PROD_W'(r1_px) * brs_pkg::PROD_W'(r_step_x);
            r2_sy   <= brs_pkg::PROD_W'(r1_py) * brs_pkg::PROD_W'(r_step_y);
        end
    end

    // stage 3: clamp to source, tap coordinates
    logic                      r3_kind, r3_ok;
    logic [brs_pkg::PIX_W-1:0] r3_pix;
    logic [XW-1:0]             r3_n, r3_nr;
    logic [YW-1:0]             r3_m, r3_mb;
    logic [FRAC_BITS-1:0]      r3_g, r3_f;

    logic [XW-1:0]        w_n, w_nr;
    logic [YW-1:0]        w_m, w_mb;
    logic [FRAC_BITS-1:0] w_g, w_f;
    logic [IPW-1:0]       w_ix, w_iy;

    always_comb begin
        w_ix = r2_sx[brs_pkg::PROD_W-1:FRAC_BITS];
        w_iy = r2_sy[brs_pkg::PROD_W-1:FRAC_BITS];
        if (32'(w_ix) > 32'(w_last_x)) begin
            w_n = w_last_x;
            w_g = '0;
        end else begin
            w_n = XW'(w_ix);
            w_g = r2_sx[FRAC_BITS-1:0];
        end
        if (32'(w_iy) > 32'(w_last_y)) begin
            w_m = w_last_y;
            w_f = '0;
        end else begin
            w_m = YW'(w_iy);
            w_f = r2_sy[FRAC_BITS-1:0];
        end
        w_nr = (w_n == w_last_x) ? w_n : w_n + XW'(1);
        w_mb = (w_m == w_last_y) ? w_m : w_m + YW'(1);
        if (r2_kind == brs_pkg::KIND_LOAD) begin
            w_n  = XW'(r2_px);
            w_nr = XW'(r2_px);
            w_m  = YW'(r2_py);
            w_mb = YW'(r2_py);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_kind <= r2_kind;
            r3_ok   <= r2_ok;
            r3_pix  <= r2_pix;
            r3_n    <= w_n;
            r3_nr   <= w_nr;
            r3_m    <= w_m;
            r3_mb   <= w_mb;
            r3_g    <= w_g;
            r3_f    <= w_f;
        end
    end

    // stage 3 -> 4: bank access and weights
    logic [BAW-1:0]           w_baddr [4];
    logic [brs_pkg::PIX_W-1:0] w_bdata [4];
    logic                     w_we    [4];
    logic [XW-1:0]            w_bcol  [4];
    logic [YW-1:0]            w_brow  [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        // bank parity: [1] row, [0] column
        localparam logic [1:0] BSEL = 2'(b);

        always_comb begin
            w_bcol[b]  = (r3_n[0] == BSEL[0]) ? r3_n : r3_nr;
            w_brow[b]  = (r3_m[0] == BSEL[1]) ? r3_m : r3_mb;
            w_baddr[b] = BAW'((32'(w_brow[b]) >> 1) * HALF_W + (32'(w_bcol[b]) >> 1));
            w_we[b]    = w_en && r_v3 && (r3_kind == brs_pkg::KIND_LOAD) && r3_ok
                         && (r3_n[0] == BSEL[0]) && (r3_m[0] == BSEL[1]);
        end

        brs_ram #(
            .WIDTH (brs_pkg::PIX_W),
            .DEPTH (BDEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_baddr[b]),
            .i_wdata (r3_pix),
            .i_re    (w_en),
            .i_raddr (w_baddr[b]),
            .o_rdata (w_bdata[b])
        );
    end

    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
    logic [WW-1:0]   w_fc, w_gc;
    logic [2*WW-1:0] w_p0, w_p1, w_p2, w_p3;

    assign w_fc = ONE - WW'(r3_f);
    assign w_gc = ONE - WW'(r3_g);
    assign w_p0 = (2*WW)'(w_fc) * (2*WW)'(w_gc);
    assign w_p1 = (2*WW)'(w_fc) * (2*WW)'(r3_g);
    assign w_p2 = (2*WW)'(r3_f) * (2*WW)'(w_gc);
    assign w_p3 = (2*WW)'(r3_f) * (2*WW)'(r3_g);

    logic            r4_kind, r4_ok;
    logic [WW-1:0]   r4_w [4];
    logic [1:0]      r4_sel [4];     // bank of each tap: {row parity, col parity}

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_kind   <= r3_kind;
            r4_ok     <= r3_ok;
            r4_w[0]   <= WW'(w_p0 >> FRAC_BITS);
            r4_w[1]   <= WW'(w_p1 >> FRAC_BITS);
            r4_w[2]   <= WW'(w_p2 >> FRAC_BITS);
            r4_w[3]   <= WW'(w_p3 >> FRAC_BITS);
            r4_sel[0] <= {r3_m[0],  r3_n[0]};
            r4_sel[1] <= {r3_m[0],  r3_nr[0]};
            r4_sel[2] <= {r3_mb[0], r3_n[0]};
            r4_sel[3] <= {r3_mb[0], r3_nr[0]};
        end
    end

    // stage 4 -> out: blend per channel
    logic [brs_pkg::PIX_W-1:0] w_tap [4];
    logic [ACC_W-1:0]          w_acc [3];
    logic [brs_pkg::PIX_W-1:0] w_rgb;          // red[7:0], green[15:8], blue[23:16]

    always_comb begin
        for (int k = 0; k < 4; k++)
            w_tap[k] = w_bdata[r4_sel[k]];
        for (int c = 0; c < 3; c++) begin
            w_acc[c] = '0;
            for (int k = 0; k < 4; k++)
                w_acc[c] = w_acc[c] + ACC_W'(r4_w[k])
                         * ACC_W'(w_tap[k][(16 - 8*c) +: brs_pkg::CHAN_W]);
            w_rgb[8*c +: brs_pkg::CHAN_W] = r4_ok ? w_acc[c][FRAC_BITS +: brs_pkg::CHAN_W]
                                                  : '0;
        end
    end

    logic [brs_pkg::OUT_TDATA_W-1:0] r_odata;
    assign o_m_tdata = r_odata;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= {7'd0, r4_ok, w_rgb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4 && (r4_kind == brs_pkg::KIND_REQ);
        end
    end

`ifndef SYNTH
    // a flagged request carries black
    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[24]) |-> (o_m_tdata[23:0] == '0))
        else $error("out-of-range result not zero");

    // bilinear weights never exceed unity
    a_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> ((ACC_W'(r4_w[0]) + ACC_W'(r4_w[1]) + ACC_W'(r4_w[2])
                   + ACC_W'(r4_w[3])) <= ACC_W'(ONE)))
        else $error("weight sum above one");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_v4 && (r4_kind == brs_pkg::KIND_LOAD)) |=> !o_m_tvalid)
        else $error("load produced a result");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear RGB scaler core: directed table, then
// randomised phases with their own register settings; random request results
// are checked against an in-bench bilinear predictor and frame store copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_W    = brs_pkg::DEF_MAX_SRC_WIDTH;
    localparam int MAX_H    = brs_pkg::DEF_MAX_SRC_HEIGHT;
    localparam int FB       = brs_pkg::DEF_FRAC_BITS;
    localparam int ONE      = 1 << FB;
    localparam int WD_LIMIT = 5000;
    localparam int HOLD_LEN = 300;

    typedef struct {
        logic             kind;
        int               x;
        int               y;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        bit               typed;
        logic [31:0]      pixel_out;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [brs_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [brs_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [brs_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [brs_pkg::STEP_W-1:0]      i_cfg_data;

    // bench copy of the registers and the frame store
    logic [brs_pkg::SRC_W-1:0]  m_src_w, m_src_h;
    logic [brs_pkg::DST_W-1:0]  m_dst_w, m_dst_h;
    logic [brs_pkg::STEP_W-1:0] m_step_x, m_step_y;
    logic [23:0]                pix_store [int];

    logic [31:0] pixels_due [$];
    int          errors = 0;
    bit          idle_on;
    bit          hold_req;
    bit          hold_done = 1'b0;
    int          hold_cnt = 0;
    int          quiet_cnt;
    int          n_items;

    bilinear_rgb_image_scaler_core u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // effective sizes after the block's own clamping
    function automatic int src_w_eff();
        return (m_src_w < 1) ? 1 : (m_src_w > MAX_W) ? MAX_W : int'(m_src_w);
    endfunction
    function automatic int src_h_eff();
        return (m_src_h < 1) ? 1 : (m_src_h > MAX_H) ? MAX_H : int'(m_src_h);
    endfunction
    function automatic int dst_w_eff();
        return (m_dst_w < 1) ? 1 : int'(m_dst_w);
    endfunction
    function automatic int dst_h_eff();
        return (m_dst_h < 1) ? 1 : int'(m_dst_h);
    endfunction

    // source coordinate: integer part saturated to the last column/row
    function automatic void split_axis(input int pos, input int step, input int size,
                                       output int ip, output int fr);
        longint p;
        p  = longint'(pos) * longint'(step);
        ip = int'(p >> FB);
        fr = int'(p & (ONE - 1));
        if (ip > size - 1) begin
            ip = size - 1;
            fr = 0;
        end
    endfunction

    // four tap addresses plus the two fractions of an in-range request
    function automatic void tap_addrs(input int x, input int y, output int addr [4],
                                      output int fr_row, output int fr_col);
        int n, m, nr, mb, sw, sh;
        sw = src_w_eff();
        sh = src_h_eff();
        split_axis(x, int'(m_step_x), sw, n, fr_col);
        split_axis(y, int'(m_step_y), sh, m, fr_row);
        nr = (n + 1 > sw - 1) ? sw - 1 : n + 1;
        mb = (m + 1 > sh - 1) ? sh - 1 : m + 1;
        addr[0] = m * MAX_W + n;
        addr[1] = m * MAX_W + nr;
        addr[2] = mb * MAX_W + n;
        addr[3] = mb * MAX_W + nr;
    endfunction

    function automatic logic [31:0] blend_pixel(input int x, input int y);
        int          addr [4];
        longint      w [4];
        longint      f, g, acc;
        logic [23:0] tap;
        logic [7:0]  chan [3];
        int          fr, fc;
        if (x >= dst_w_eff() || y >= dst_h_eff()) return 32'd0;
        tap_addrs(x, y, addr, fr, fc);
        f = fr;
        g = fc;
        w[0] = ((ONE - f) * (ONE - g)) >> FB;
        w[1] = ((ONE - f) * g) >> FB;
        w[2] = (f * (ONE - g)) >> FB;
        w[3] = (f * g) >> FB;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                tap = pix_store.exists(addr[k]) ? pix_store[addr[k]] : 24'd0;
                acc += w[k] * longint'((tap >> (16 - 8 * c)) & 24'hFF);
            end
            chan[c] = acc[FB+7:FB];
        end
        return {7'd0, 1'b1, chan[2], chan[1], chan[0]};
    endfunction

    // one item over the slave stream; predictor updated at acceptance
    task automatic send_item(input t_row row);
        while (idle_on && quiet_cnt == 0 && $urandom_range(0, 99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= row.kind;
        i_s_tdata  <= {row.b, row.g, row.r, row.y[brs_pkg::POS_W-1:0],
                       row.x[brs_pkg::POS_W-1:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (quiet_cnt > 0) quiet_cnt--;
        n_items++;
        if (row.kind == brs_pkg::KIND_LOAD) begin
            if (row.x < MAX_W && row.y < MAX_H)
                pix_store[row.y * MAX_W + row.x] = {row.r, row.g, row.b};
        end else if (row.typed) begin
            pixels_due.push_back(row.pixel_out);
        end else begin
            pixels_due.push_back(blend_pixel(row.x, row.y));
        end
    endtask

    task automatic drain_and_settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input brs_pkg::t_cfg_idx idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[brs_pkg::STEP_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            brs_pkg::CFG_SRC_WIDTH:  m_src_w  = val[brs_pkg::SRC_W-1:0];
            brs_pkg::CFG_SRC_HEIGHT: m_src_h  = val[brs_pkg::SRC_W-1:0];
            brs_pkg::CFG_DST_WIDTH:  m_dst_w  = val[brs_pkg::DST_W-1:0];
            brs_pkg::CFG_DST_HEIGHT: m_dst_h  = val[brs_pkg::DST_W-1:0];
            brs_pkg::CFG_STEP_X:     m_step_x = val[brs_pkg::STEP_W-1:0];
            brs_pkg::CFG_STEP_Y:     m_step_y = val[brs_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int sw, input int sh, input int dw, input int dh,
                            input int sx, input int sy);
        write_reg(brs_pkg::CFG_SRC_WIDTH, sw);
        write_reg(brs_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(brs_pkg::CFG_DST_WIDTH, dw);
        write_reg(brs_pkg::CFG_DST_HEIGHT, dh);
        write_reg(brs_pkg::CFG_STEP_X, sx);
        write_reg(brs_pkg::CFG_STEP_Y, sy);
    endtask

    function automatic t_row make_row(input logic k, input int x, input int y);
        t_row row;
        row.kind  = k;
        row.x     = x;
        row.y     = y;
        row.r     = 8'($urandom);
        row.g     = 8'($urandom);
        row.b     = 8'($urandom);
        row.typed = 1'b0;
        row.pixel_out = '0;
        return row;
    endfunction

    // one random step: noise load, out-of-range request, or an in-range request
    // preceded by loads for any tap not yet written
    task automatic random_step();
        int   sel, x, y, fr, fc;
        int   addr [4];
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            send_item(make_row(brs_pkg::KIND_LOAD, $urandom_range(0, 4095),
                               $urandom_range(0, 4095)));
        end else if (sel < 20 && (dst_w_eff() < 4096 || dst_h_eff() < 4096)) begin
            // only when some position lies past the destination size
            if (dst_w_eff() < 4096 && (dst_h_eff() >= 4096 || $urandom_range(0, 1) == 1)) begin
                x = $urandom_range(dst_w_eff(), 4095);
                y = $urandom_range(0, 4095);
            end else begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(dst_h_eff(), 4095);
            end
            send_item(make_row(brs_pkg::KIND_REQ, x, y));
        end else begin
            x = $urandom_range(0, ((dst_w_eff() > 4096) ? 4096 : dst_w_eff()) - 1);
            y = $urandom_range(0, ((dst_h_eff() > 4096) ? 4096 : dst_h_eff()) - 1);
            tap_addrs(x, y, addr, fr, fc);
            for (int k = 0; k < 4; k++)
                if (!pix_store.exists(addr[k]))
                    send_item(make_row(brs_pkg::KIND_LOAD, addr[k] % MAX_W, addr[k] / MAX_W));
            send_item(make_row(brs_pkg::KIND_REQ, x, y));
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                logic [31:0] want;
                want = pixels_due.pop_front();
                if (o_m_tdata !== want) begin
                    $display("%0t: result mismatch, expected r=%h g=%h b=%h rng=%b top=%h",
                             $time, want[7:0], want[15:8], want[23:16], want[24], want[31:25]);
                    $display("%0t:                  actual   r=%h g=%h b=%h rng=%b top=%h",
                             $time, o_m_tdata[7:0], o_m_tdata[15:8], o_m_tdata[23:16],
                             o_m_tdata[24], o_m_tdata[31:25]);
                    errors++;
                end
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt   <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done  <= 1'b1;
            hold_cnt   <= HOLD_LEN;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= (idle_on && quiet_cnt == 0) ? ($urandom_range(0, 99) >= 16) : 1'b1;
        end
    end

    // watchdog on cycles without any item moving
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WD_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_row dir_rows [$];

    task automatic add_row(input logic k, input int x, input int y, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input bit typed,
                           input logic [31:0] want);
        t_row row;
        row.kind = k; row.x = x; row.y = y;
        row.r = r; row.g = g; row.b = b;
        row.typed = typed; row.pixel_out = want;
        dir_rows.push_back(row);
    endtask

    initial begin
        n_items     = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        quiet_cnt   = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        m_src_w = 10'd512; m_src_h = 10'd512;
        m_dst_w = 13'd512; m_dst_h = 13'd512;
        m_step_x = 18'd256; m_step_y = 18'd256;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset register values: unit steps, fraction zero
        add_row(brs_pkg::KIND_LOAD, 0, 0, 8'hFF, 8'h00, 8'h80, 0, 0);
        add_row(brs_pkg::KIND_LOAD, 1, 0, 8'h11, 8'h22, 8'h33, 0, 0);
        add_row(brs_pkg::KIND_LOAD, 0, 1, 8'h44, 8'h55, 8'h66, 0, 0);
        add_row(brs_pkg::KIND_LOAD, 1, 1, 8'h77, 8'h88, 8'h99, 0, 0);
        add_row(brs_pkg::KIND_REQ,  0, 0, 8'h00, 8'h00, 8'h00, 1, 32'h018000FF);
        add_row(brs_pkg::KIND_LOAD, 511, 511, 8'h00, 8'hFF, 8'h7F, 0, 0);
        add_row(brs_pkg::KIND_REQ,  511, 511, 8'h00, 8'h00, 8'h00, 1, 32'h017FFF00);
        // requests past the destination size
        add_row(brs_pkg::KIND_REQ,  512, 0, 8'hFF, 8'hFF, 8'hFF, 1, 32'h0);
        add_row(brs_pkg::KIND_REQ,  0, 512, 8'h00, 8'h00, 8'h00, 1, 32'h0);
        add_row(brs_pkg::KIND_REQ,  4095, 4095, 8'hFF, 8'hFF, 8'hFF, 1, 32'h0);
        // loads outside the store are dropped
        add_row(brs_pkg::KIND_LOAD, 4095, 4095, 8'hAA, 8'hAA, 8'hAA, 0, 0);
        add_row(brs_pkg::KIND_LOAD, 512, 0, 8'h55, 8'h55, 8'h55, 0, 0);
        add_row(brs_pkg::KIND_LOAD, 0, 512, 8'h55, 8'h55, 8'h55, 0, 0);
        add_row(brs_pkg::KIND_REQ,  511, 511, 8'h00, 8'h00, 8'h00, 1, 32'h017FFF00);
        // colour extremes on an overwritten entry
        add_row(brs_pkg::KIND_LOAD, 0, 0, 8'h00, 8'h00, 8'h00, 0, 0);
        add_row(brs_pkg::KIND_REQ,  0, 0, 8'h00, 8'h00, 8'h00, 1, 32'h01000000);
        add_row(brs_pkg::KIND_LOAD, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0);
        add_row(brs_pkg::KIND_REQ,  0, 0, 8'h00, 8'h00, 8'h00, 1, 32'h01FFFFFF);
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        drain_and_settle();

        // random phases, phases 1 to 4 at the register extremes
        for (int ph = 0; n_items < 650; ph++) begin
            case (ph)
                0: set_regs(4, 4, 16, 16, 64, 64);
                1: set_regs(1, 0, 8, 0, 0, 131072);
                2: set_regs(1023, 512, 4096, 4096, 131072, 0);
                3: set_regs(512, 1023, 0, 4096, 262143, 255);
                4: set_regs(1023, 1023, 8191, 8191, 300, 300);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_regs($urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(0, 262143), $urandom_range(0, 262143));
                    else
                        set_regs($urandom_range(1, 12), $urandom_range(1, 12),
                                 $urandom_range(1, 40), $urandom_range(1, 40),
                                 $urandom_range(0, 600), $urandom_range(0, 600));
                end
            endcase
            if (ph == 1) hold_req = 1'b1;     // receiver holds off, input backs up
            if (ph == 2) quiet_cnt = 70;      // stretch with no idling either side
            for (int k = 0; k < 40; k++) random_step();
            drain_and_settle();
        end

        if (errors == 0 && pixels_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/brs_pkg.sv
rtl/brs_ram.sv
rtl/bilinear_rgb_image_scaler_core.sv
tb/testbench.sv
